// ===== hw/rtl/dotted_quad_ip_parser_assert.svh =====
// Assertion macros shared by the dotted-quad parser RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef DOTTED_QUAD_IP_PARSER_ASSERT_SVH
`define DOTTED_QUAD_IP_PARSER_ASSERT_SVH

// Clocked check, switched off while reset is high.
`define DQIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define DQIP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dqip_pkg.sv =====
// Types and character constants for the dotted-quad address parser.
// Depends on nothing; used by the channel interfaces and the top level.
package dqip_pkg;

   typedef logic [7:0] octet_type;
   typedef logic [7:0] char_type;

   // Character codes
   localparam char_type CH_ZERO = 8'h30;
   localparam char_type CH_NINE = 8'h39;
   localparam char_type CH_DOT  = 8'h2E;

   // Octet value that never appears in a valid address
   localparam octet_type OCTET_FORBIDDEN = 8'hFF;

   // Group and dot limits
   localparam logic [1:0] MAX_GROUP_DIGITS = 2'd3;
   localparam logic [2:0] DOTS_NEEDED      = 3'd3;
   localparam logic [2:0] DOT_SAT          = 3'd4;

   // Result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

endpackage

// ===== hw/rtl/dqip_req_if.sv =====
// Character channel of the dotted-quad parser: valid/ready, one character and a last flag.
// Depends on dqip_pkg.
interface dqip_req_if;
   import dqip_pkg::*;

   logic     valid;
   logic     ready;
   char_type ch;
   logic     last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);

endinterface

// ===== hw/rtl/dqip_rsp_if.sv =====
// Result channel of the dotted-quad parser: valid/ready, status and four octets.
// Depends on dqip_pkg.
interface dqip_rsp_if;
   import dqip_pkg::*;

   logic      valid;
   logic      ready;
   logic      status;
   octet_type octet_a;
   octet_type octet_b;
   octet_type octet_c;
   octet_type octet_d;

   modport source (output valid, output status, output octet_a, output octet_b,
                   output octet_c, output octet_d, input ready);
   modport sink   (input valid, input status, input octet_a, input octet_b,
                   input octet_c, input octet_d, output ready);

endinterface

// ===== hw/rtl/dotted_quad_ip_parser.sv =====
// Dotted-quad IPv4 address parser, one character beat per cycle.
// The result beat is registered and becomes valid in the cycle after the beat flagged last.
// Throughput: one character per cycle; input stalls only while a result waits.
// The result register parts the two channels, so a new character is taken
// in the same cycle that a waiting result is drained.
// Reset (synchronous, active high) clears the parse state and the result valid.
// Depends on dqip_pkg, dqip_req_if, dqip_rsp_if and the assertion header.
module dotted_quad_ip_parser (
   input logic       clock,
   input logic       reset,
   dqip_req_if.sink  req_if,
   dqip_rsp_if.source rsp_if
);
   import dqip_pkg::*;

   `include "dotted_quad_ip_parser_assert.svh"

   // Parse state
   logic            bad_seen_ff, bad_seen_in;
   logic [2:0]      dot_count_ff, dot_count_in;
   logic [1:0]      group_digits_ff, group_digits_in;
   logic [9:0]      group_value_ff, group_value_in;
   octet_type       done_octets_ff [3];
   octet_type       done_octets_in [3];

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            status_ff, status_in;
   octet_type       octet_a_ff, octet_a_in;
   octet_type       octet_b_ff, octet_b_in;
   octet_type       octet_c_ff, octet_c_in;
   octet_type       octet_d_ff, octet_d_in;

   // State after the current character, before the end-of-string clear
   logic            upd_bad;
   logic [2:0]      upd_dots;
   logic [1:0]      upd_digits;
   logic [9:0]      upd_value;
   octet_type       upd_octets [3];

   logic            accept;
   logic            load;
   logic            is_digit;
   logic            is_dot;
   logic [3:0]      digit;
   octet_type       last_octet;
   logic            addr_ok;

   // Take a beat whenever the result register is empty or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign load         = accept && req_if.last;

   // Classify the character
   assign is_digit = (req_if.ch inside {[CH_ZERO:CH_NINE]});
   assign is_dot   = (req_if.ch == CH_DOT);
   assign digit    = 4'(req_if.ch - CH_ZERO);

   // Advance the parse state by one character
   always_comb begin
      upd_bad    = bad_seen_ff;
      upd_dots   = dot_count_ff;
      upd_digits = group_digits_ff;
      upd_value  = group_value_ff;
      for (int k = 0; k < 3; k++) begin
         upd_octets[k] = done_octets_ff[k];
      end
      if (is_digit) begin
         if (group_digits_ff >= MAX_GROUP_DIGITS) begin
            upd_bad = 1'b1;
         end else begin
            upd_digits = group_digits_ff + 2'd1;
            // value * 10 + digit; at most 999 with fewer than three digits held
            upd_value  = (group_value_ff << 3) + (group_value_ff << 1) + 10'(digit);
         end
      end else if (is_dot) begin
         // Close the group into the octet slot picked by the dot count
         for (int k = 0; k < 3; k++) begin
            if (dot_count_ff == 3'(k)) begin
               upd_octets[k] = group_value_ff[7:0];
            end
         end
         if (dot_count_ff < DOT_SAT) begin
            upd_dots = dot_count_ff + 3'd1;
         end
         upd_digits = '0;
         upd_value  = '0;
      end else begin
         upd_bad = 1'b1;
      end
   end

   // Judge the address as it stands after this character
   assign last_octet = upd_value[7:0];
   assign addr_ok = !upd_bad && (upd_dots == DOTS_NEEDED)
                    && (upd_octets[0] != OCTET_FORBIDDEN)
                    && (upd_octets[1] != OCTET_FORBIDDEN)
                    && (upd_octets[2] != OCTET_FORBIDDEN)
                    && (last_octet    != OCTET_FORBIDDEN)
                    && (upd_octets[0] != 8'd0)
                    && (last_octet    != 8'd0);

   // Commit the state; drop it all at the end of a string
   always_comb begin
      bad_seen_in     = bad_seen_ff;
      dot_count_in    = dot_count_ff;
      group_digits_in = group_digits_ff;
      group_value_in  = group_value_ff;
      for (int k = 0; k < 3; k++) begin
         done_octets_in[k] = done_octets_ff[k];
      end
      if (accept) begin
         if (req_if.last) begin
            bad_seen_in     = 1'b0;
            dot_count_in    = '0;
            group_digits_in = '0;
            group_value_in  = '0;
            for (int k = 0; k < 3; k++) begin
               done_octets_in[k] = '0;
            end
         end else begin
            bad_seen_in     = upd_bad;
            dot_count_in    = upd_dots;
            group_digits_in = upd_digits;
            group_value_in  = upd_value;
            for (int k = 0; k < 3; k++) begin
               done_octets_in[k] = upd_octets[k];
            end
         end
      end
   end

   // Load the result beat on the last character, hold it until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      octet_a_in   = octet_a_ff;
      octet_b_in   = octet_b_ff;
      octet_c_in   = octet_c_ff;
      octet_d_in   = octet_d_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         status_in    = addr_ok ? STATUS_OK : STATUS_BAD;
         octet_a_in   = addr_ok ? upd_octets[0] : 8'd0;
         octet_b_in   = addr_ok ? upd_octets[1] : 8'd0;
         octet_c_in   = addr_ok ? upd_octets[2] : 8'd0;
         octet_d_in   = addr_ok ? last_octet    : 8'd0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bad_seen_ff     <= 1'b0;
         dot_count_ff    <= '0;
         group_digits_ff <= '0;
         group_value_ff  <= '0;
         for (int k = 0; k < 3; k++) begin
            done_octets_ff[k] <= '0;
         end
         rsp_valid_ff    <= 1'b0;
      end else begin
         bad_seen_ff     <= bad_seen_in;
         dot_count_ff    <= dot_count_in;
         group_digits_ff <= group_digits_in;
         group_value_ff  <= group_value_in;
         for (int k = 0; k < 3; k++) begin
            done_octets_ff[k] <= done_octets_in[k];
         end
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      octet_a_ff <= octet_a_in;
      octet_b_ff <= octet_b_in;
      octet_c_ff <= octet_c_in;
      octet_d_ff <= octet_d_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = status_ff;
   assign rsp_if.octet_a = octet_a_ff;
   assign rsp_if.octet_b = octet_b_ff;
   assign rsp_if.octet_c = octet_c_ff;
   assign rsp_if.octet_d = octet_d_ff;

   // Checks
   `DQIP_ASSERT(a_last_gives_result, clock, reset, load |=> rsp_valid_ff, "last beat gave no result")
   `DQIP_ASSERT(a_last_clears_state, clock, reset, load |=> (!bad_seen_ff && dot_count_ff == 3'd0 && group_digits_ff == 2'd0 && group_value_ff == 10'd0), "state not cleared after last beat")
   `DQIP_ASSERT(a_bad_zero_octets, clock, reset, (rsp_valid_ff && status_ff == STATUS_BAD) |-> (octet_a_ff == 8'd0 && octet_b_ff == 8'd0 && octet_c_ff == 8'd0 && octet_d_ff == 8'd0), "bad address with nonzero octets")
   `DQIP_ASSERT(a_ok_octets_legal, clock, reset, (rsp_valid_ff && status_ff == STATUS_OK) |-> (octet_a_ff != 8'd0 && octet_d_ff != 8'd0 && octet_b_ff != OCTET_FORBIDDEN), "valid address with illegal octet")
   `DQIP_ASSERT_ALWAYS(a_dots_saturate, clock, reset || (dot_count_ff <= DOT_SAT), "dot count beyond saturation")

endmodule

// ===== tb/sv/dotted_quad_ip_parser_tb.sv =====
// Self-checking testbench for the dotted-quad address parser.
// Depends on dqip_pkg, dqip_req_if, dqip_rsp_if and dotted_quad_ip_parser;
// predicts each result in-line and checks it against the result channel.
`timescale 1ns / 1ps

module dotted_quad_ip_parser_tb;
   import dqip_pkg::*;

   typedef struct packed {
      logic      status;
      octet_type octet_a;
      octet_type octet_b;
      octet_type octet_c;
      octet_type octet_d;
   } address_verdict_type;

   localparam int unsigned IDLE_PCT      = 28;
   localparam int unsigned STALL_LIMIT   = 3000;
   localparam int unsigned HOLDOFF_LEN   = 150;
   localparam int unsigned RESULT_LAG    = 4;
   localparam int unsigned ITEMS_PART1   = 700;
   localparam int unsigned ITEMS_TOTAL   = 1450;

   logic clock;
   logic reset;

   dqip_req_if req_bus ();
   dqip_rsp_if rsp_bus ();

   dotted_quad_ip_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Parse state of the predictor
   logic        parse_bad;
   logic [2:0]  parse_dots;
   logic [1:0]  parse_digits;
   logic [9:0]  parse_value;
   octet_type   parse_octets [3];

   address_verdict_type pending_verdicts [$];

   int unsigned error_count;
   int unsigned chars_sent;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned holdoff_left;
   int unsigned stall_cycles;

   // Clock: 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic clear_parse();
      parse_bad    = 1'b0;
      parse_dots   = '0;
      parse_digits = '0;
      parse_value  = '0;
      foreach (parse_octets[i]) parse_octets[i] = '0;
   endtask

   // Advance the parse state by one character; queue a verdict on the last one
   task automatic absorb_char(input char_type c, input logic is_last);
      octet_type           quad [4];
      address_verdict_type verdict;
      logic                ok;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (parse_digits >= MAX_GROUP_DIGITS) begin
            parse_bad = 1'b1;
         end else begin
            parse_digits++;
            parse_value = parse_value * 10'd10 + 10'(c - CH_ZERO);
         end
      end else if (c == CH_DOT) begin
         if (parse_dots < DOTS_NEEDED) parse_octets[parse_dots[1:0]] = parse_value[7:0];
         if (parse_dots < DOT_SAT) parse_dots++;
         parse_digits = '0;
         parse_value  = '0;
      end else begin
         parse_bad = 1'b1;
      end
      if (!is_last) return;

      quad[0] = parse_octets[0];
      quad[1] = parse_octets[1];
      quad[2] = parse_octets[2];
      quad[3] = parse_value[7:0];
      ok = !parse_bad && parse_dots == DOTS_NEEDED;
      foreach (quad[i]) if (quad[i] == OCTET_FORBIDDEN) ok = 1'b0;
      if (quad[0] == 8'd0 || quad[3] == 8'd0) ok = 1'b0;

      verdict.status  = ok ? STATUS_OK : STATUS_BAD;
      verdict.octet_a = ok ? quad[0] : 8'd0;
      verdict.octet_b = ok ? quad[1] : 8'd0;
      verdict.octet_c = ok ? quad[2] : 8'd0;
      verdict.octet_d = ok ? quad[3] : 8'd0;
      pending_verdicts.push_back(verdict);
      clear_parse();
   endtask

   // Offer one character beat, idling at random first; predict on acceptance
   task automatic send_char(input char_type c, input logic is_last);
      @(negedge clock);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.ch    = c;
      req_bus.last  = is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_char(c, is_last);
      chars_sent++;
   endtask

   task automatic send_text(input char_type text [$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_ascii(input string s);
      char_type text [$];
      for (int i = 0; i < s.len(); i++) text.push_back(char_type'(s[i]));
      send_text(text);
   endtask

   // Drop valid and hold until every expected result has drained
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (RESULT_LAG) @(posedge clock);
   endtask

   // Append a decimal group, zero-padded to width digits
   task automatic append_group(ref char_type text [$], input int unsigned value,
                               input int unsigned width);
      int unsigned digs [$];
      int unsigned v;
      v = value;
      do begin
         digs.push_front(v % 10);
         v = v / 10;
      end while (v != 0);
      while (digs.size() < width) digs.push_front(0);
      foreach (digs[i]) text.push_back(char_type'(CH_ZERO + digs[i]));
   endtask

   function automatic int unsigned pick_group_value();
      case ($urandom_range(9))
         0: return 0;
         1: return 255;
         2: return $urandom_range(256, 999);
         3: return $urandom_range(1, 9);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Build one address: mostly well formed, some broken, some pure noise
   task automatic build_address(ref char_type text [$]);
      int unsigned kind;
      int unsigned groups;
      int unsigned spoil;
      kind   = $urandom_range(99);
      groups = 4;
      if (kind >= 90) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(3))
               0: text.push_back(CH_DOT);
               1: text.push_back(char_type'($urandom_range(CH_ZERO, CH_NINE)));
               default: text.push_back(char_type'($urandom_range(0, 255)));
            endcase
         end
         return;
      end
      if (kind >= 70 && kind < 80) groups = $urandom_range(1, 6);
      spoil = (kind >= 80) ? $urandom_range(1, 2) : 0;
      for (int g = 0; g < groups; g++) begin
         if (g > 0) text.push_back(CH_DOT);
         if ($urandom_range(99) < 5) continue;
         if (spoil == 2 && g == groups - 1)
            append_group(text, $urandom_range(0, 999), $urandom_range(4, 5));
         else
            append_group(text, pick_group_value(),
                         ($urandom_range(99) < 20) ? $urandom_range(3) : 0);
      end
      if (spoil == 1) text.insert($urandom_range(text.size()), char_type'($urandom_range(0, 255)));
      if (text.size() == 0) text.push_back(CH_DOT);
   endtask

   task automatic send_random_address();
      char_type text [$];
      build_address(text);
      send_text(text);
   endtask

   // Test: field extremes and each special case
   task automatic test_directed_cases();
      char_type text [$];
      send_ascii("1.2.3.4");
      send_ascii("001.002.003.004");
      send_ascii("999.1.0.254");
      send_ascii("255.1.1.1");
      send_ascii("1.1.1.255");
      send_ascii("511.1.1.1");
      send_ascii("0.1.1.1");
      send_ascii("1.1.1.0");
      send_ascii("256.1.1.1");
      send_ascii("1..1.1");
      send_ascii("...");
      send_ascii("1.2.3");
      send_ascii("1.2.3.4.5");
      send_ascii("1.2.3.4.5.6.7");
      send_ascii("1234.1.1.1");
      send_ascii("1.2.3.4x");
      send_ascii("1/2.3:4");
      send_ascii("7");
      send_ascii(".");
      text = '{8'h31, 8'h00, 8'h2E, 8'hFF, 8'h2E, 8'h32, 8'h2E, 8'h33};
      send_text(text);
      wait_drained();
   endtask

   // Test: random addresses until the character count is reached
   task automatic test_random_addresses(input int unsigned char_target);
      while (chars_sent < char_target) send_random_address();
      wait_drained();
   endtask

   // Test: back-to-back beats with neither side idling
   task automatic test_quiet_stretch();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (12) send_random_address();
      wait_drained();
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   // Test: result side holds off while characters keep coming, input must stall
   task automatic test_result_holdoff();
      holdoff_left = HOLDOFF_LEN;
      repeat (8) send_random_address();
      send_ascii("10.20.30.40");
      wait_drained();
   endtask

   // Result-side ready: random idling, or a counted hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_left != 0) begin
            rsp_bus.ready = 1'b0;
            holdoff_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_results
      address_verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.octet_a !== want.octet_a)
               report_mismatch("octet_a", rsp_bus.octet_a, want.octet_a);
            if (rsp_bus.octet_b !== want.octet_b)
               report_mismatch("octet_b", rsp_bus.octet_b, want.octet_b);
            if (rsp_bus.octet_c !== want.octet_c)
               report_mismatch("octet_c", rsp_bus.octet_c, want.octet_c);
            if (rsp_bus.octet_d !== want.octet_d)
               report_mismatch("octet_d", rsp_bus.octet_d, want.octet_d);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] timeout: no beat for %0d cycles", $time, stall_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      chars_sent    = 0;
      stall_cycles  = 0;
      holdoff_left  = 0;
      req_idle_pct  = IDLE_PCT;
      rsp_idle_pct  = IDLE_PCT;
      req_bus.valid = 1'b0;
      req_bus.ch    = '0;
      req_bus.last  = 1'b0;
      reset         = 1'b1;
      clear_parse();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_addresses(ITEMS_PART1);
      test_quiet_stretch();
      test_result_holdoff();
      test_random_addresses(ITEMS_TOTAL);

      if (pending_verdicts.size() != 0)
         report_mismatch("results never delivered", 0, pending_verdicts.size());
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
